>>> rtl/core/tba_pkg.sv
package tba_pkg;

  localparam int TS_W  = 64;
  localparam int VAL_W = 64;
  localparam int BW_W  = 32;
  localparam int MODE_W = 3;

  // aggregate kinds
  localparam logic [MODE_W-1:0] MODE_COUNT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MIN   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MAX   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SUM   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DIFF  = 3'd4;

  // register indexes
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic take;       // latch the input beat
    logic close;      // close open bucket, emit group result if clean
    logic div_start;  // start boundary remainder
    logic open_bkt;   // open new bucket from the latched point
    logic update;     // fold the latched point into the open bucket
    logic emit_final; // emit last result and clear the series
  } tba_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic close_hit;
    logic bucket_open;
    logic div_done;
    logic out_busy;
    logic last;
  } tba_sts_t;

endpackage

>>> rtl/core/time_bucket_aggregator.sv
// channel  | direction | tdata                                | tuser   | tlast
// s_*      | in        | [63:0] timestamp, [127:64] sample_value | -     | series_end
// m_*      | out       | [63:0] bucket_time, [127:64] aggregate_value | status | final_result
// cfg_*    | in        | cfg_index 0 mode, 1 bucket_width; no read-back
//
// a point that opens a new bucket waits for its boundary, which comes from a
// bit-serial remainder, one timestamp bit per cycle; a point that joins the open
// bucket needs no boundary. a closing or final result waits in the output
// register; the block stalls only if a second result is due before the first
// is taken. rst is synchronous and clears the series and the registers.
module time_bucket_aggregator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // timestamp, sample_value
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // bucket_time, aggregate_value
  output logic         m_tuser,   // status
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  import tba_pkg::*;

  tba_cmd_t cmd;
  tba_sts_t sts;
  logic signed [VAL_W-1:0] out_value;

  tba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tba_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ts      (s_tdata[63:0]),
    .in_val     (s_tdata[127:64]),
    .in_last    (s_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_time   (m_tdata[63:0]),
    .out_value  (out_value),
    .out_status (m_tuser),
    .out_final  (m_tlast)
  );

  assign m_tdata[127:64] = out_value;

endmodule

>>> rtl/core/tba_ctrl.sv
module tba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tba_pkg::tba_sts_t sts,
  output tba_pkg::tba_cmd_t cmd
);
  import tba_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;

  logic [2:0] state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.close_hit) state_next = S_START;
        else if (!sts.out_busy) begin
          cmd.close  = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.bucket_open) begin
          cmd.update = 1'b1;
          state_next = S_LAST;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.open_bkt = 1'b1;
          state_next   = S_LAST;
        end
      end
      S_LAST: begin
        if (!sts.last) state_next = S_IDLE;
        else if (!sts.out_busy) begin
          cmd.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/tba_dp.sv
module tba_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [tba_pkg::BW_W-1:0]     cfg_data,
  input  logic [tba_pkg::TS_W-1:0]     in_ts,
  input  logic signed [tba_pkg::VAL_W-1:0] in_val,
  input  logic                         in_last,
  input  tba_pkg::tba_cmd_t            cmd,
  output tba_pkg::tba_sts_t            sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tba_pkg::TS_W-1:0]     out_time,
  output logic signed [tba_pkg::VAL_W-1:0] out_value,
  output logic                         out_status,
  output logic                         out_final
);
  import tba_pkg::*;

  logic [MODE_W-1:0] mode;
  logic [BW_W-1:0]   bwidth;

  logic [TS_W-1:0]         pt_ts;
  logic signed [VAL_W-1:0] pt_val;
  logic                    pt_last;

  logic [TS_W-1:0]         open_time;
  logic                    bucket_open;
  logic [VAL_W-2:0]        count;
  logic signed [VAL_W-1:0] first_v, latest_v, run_min, run_max, run_sum;
  logic                    ovf_seen;

  // remainder unit
  logic [BW_W-1:0] div_w, rem;
  logic [TS_W-1:0] shf;
  logic [5:0]      cnt;
  logic            dividing, div_done;
  logic [BW_W:0]   trial;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_COUNT;
      bwidth <= BW_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  mode   <= cfg_data[MODE_W-1:0];
        REG_WIDTH: bwidth <= cfg_data;
        default: ;
      endcase
    end
  end

  // input point
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pt_ts   <= in_ts;
      pt_val  <= in_val;
      pt_last <= in_last;
    end
  end

  // bit-serial remainder of the timestamp by the width
  assign trial = {rem, shf[TS_W-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      dividing <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (cmd.div_start) begin
        dividing <= 1'b1;
        div_w    <= (bwidth == '0) ? BW_W'(1) : bwidth;
        rem      <= '0;
        shf      <= pt_ts;
        cnt      <= '0;
      end else if (dividing) begin
        rem <= (trial >= {1'b0, div_w}) ? BW_W'(trial - {1'b0, div_w}) : BW_W'(trial);
        shf <= {shf[TS_W-2:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          dividing <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  // rounded-up boundary, saturating
  logic [TS_W:0]   bnd_sum;
  logic [TS_W-1:0] boundary;
  assign bnd_sum  = {1'b0, pt_ts} + {{(TS_W-BW_W+1){1'b0}}, BW_W'(div_w - rem)};
  assign boundary = (rem == '0) ? pt_ts :
                    (bnd_sum[TS_W] ? {TS_W{1'b1}} : bnd_sum[TS_W-1:0]);

  // aggregate of the open bucket
  logic [VAL_W-1:0]        diff;
  logic                    diff_ovf;
  logic signed [VAL_W-1:0] agg;
  assign diff     = latest_v - first_v;
  assign diff_ovf = (mode == MODE_DIFF) && (latest_v[VAL_W-1] != first_v[VAL_W-1]) &&
                    (diff[VAL_W-1] != latest_v[VAL_W-1]);
  always_comb begin
    unique case (mode)
      MODE_MIN:  agg = run_min;
      MODE_MAX:  agg = run_max;
      MODE_SUM:  agg = run_sum;
      MODE_DIFF: agg = diff;
      default:   agg = {1'b0, count};
    endcase
  end

  // sum of the new point
  logic [VAL_W-1:0] sum_n;
  logic             sum_ovf;
  assign sum_n   = run_sum + pt_val;
  assign sum_ovf = (mode == MODE_SUM) && (run_sum[VAL_W-1] == pt_val[VAL_W-1]) &&
                   (sum_n[VAL_W-1] != run_sum[VAL_W-1]);

  // bucket state
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_open <= 1'b0;
      ovf_seen    <= 1'b0;
      open_time   <= '0;
      count       <= '0;
      first_v     <= '0;
      latest_v    <= '0;
      run_min     <= '0;
      run_max     <= '0;
      run_sum     <= '0;
    end else if (cmd.emit_final) begin
      bucket_open <= 1'b0;
      ovf_seen    <= 1'b0;
      open_time   <= '0;
      count       <= '0;
      first_v     <= '0;
      latest_v    <= '0;
      run_min     <= '0;
      run_max     <= '0;
      run_sum     <= '0;
    end else if (cmd.close) begin
      bucket_open <= 1'b0;
      if (diff_ovf) ovf_seen <= 1'b1;
    end else if (cmd.open_bkt) begin
      bucket_open <= 1'b1;
      open_time   <= boundary;
      count       <= (VAL_W-1)'(1);
      first_v     <= pt_val;
      latest_v    <= pt_val;
      run_min     <= pt_val;
      run_max     <= pt_val;
      run_sum     <= pt_val;
    end else if (cmd.update) begin
      if (count != {(VAL_W-1){1'b1}}) count <= count + (VAL_W-1)'(1);
      latest_v <= pt_val;
      if (pt_val < run_min) run_min <= pt_val;
      if (pt_val > run_max) run_max <= pt_val;
      run_sum <= sum_n;
      if (sum_ovf) ovf_seen <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.close && !ovf_seen && !diff_ovf) begin
        out_valid  <= 1'b1;
        out_time   <= open_time;
        out_value  <= agg;
        out_status <= 1'b0;
        out_final  <= 1'b0;
      end else if (cmd.emit_final) begin
        out_valid <= 1'b1;
        out_final <= 1'b1;
        if (!ovf_seen && !diff_ovf) begin
          out_time   <= open_time;
          out_value  <= agg;
          out_status <= 1'b0;
        end else begin
          out_time   <= '0;
          out_value  <= '0;
          out_status <= 1'b1;
        end
      end
    end
  end

  assign sts.close_hit   = bucket_open && (pt_ts > open_time);
  assign sts.bucket_open = bucket_open;
  assign sts.div_done    = div_done;
  assign sts.out_busy    = out_valid;
  assign sts.last        = pt_last;

  // checks
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dividing && !cmd.div_start |-> rem < div_w)
    else $error("remainder not below width");
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_final |=> !ovf_seen && !bucket_open)
    else $error("series not cleared after final result");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.close || cmd.emit_final) |-> !out_valid)
    else $error("result register overwritten");
  a_open_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.open_bkt |-> div_done && !bucket_open)
    else $error("bucket opened without boundary");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import tba_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;   // timestamp, sample_value
  logic         s_tlast;   // series_end
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;   // bucket_time, aggregate_value
  logic         m_tuser;   // status
  logic         m_tlast;   // final_result
  logic         cfg_we;
  logic         cfg_index;
  logic [31:0]  cfg_data;

  localparam int WATCHDOG = 20000;
  localparam int SETTLE   = 200;

  typedef struct packed {
    logic [63:0] bucket_time;
    logic [63:0] agg;
    logic        status;
    logic        fin;
  } bucket_res_t;

  // predicts bucket results and checks them in order
  class bucket_scoreboard;
    logic [2:0]  mode;
    logic [31:0] width;
    logic [63:0] open_time;
    bit          is_open;
    logic [63:0] cnt;
    logic signed [63:0] first_v, last_v, min_v, max_v, sum_v;
    bit          ovf;
    bucket_res_t pending[$];
    int          errors;

    function void clear();
      open_time = 0; is_open = 0; cnt = 0;
      first_v = 0; last_v = 0; min_v = 0; max_v = 0; sum_v = 0;
    endfunction

    function void reset();
      mode = MODE_COUNT; width = 1; clear(); ovf = 0;
      pending.delete(); errors = 0;
    endfunction

    // rounded-up boundary, saturated at all ones
    function logic [63:0] boundary(logic [63:0] ts);
      logic [63:0]  w;
      logic [127:0] up;
      w = (width == 0) ? 64'd1 : {32'd0, width};
      if (ts % w == 0) return ts;
      up = ({64'd0, ts / w} + 128'd1) * {64'd0, w};
      if (up[127:64] != 0) return '1;
      return up[63:0];
    endfunction

    // returns 0 when the difference overflows
    function bit agg_of(output logic [63:0] r);
      logic [63:0] d;
      case (mode)
        MODE_MIN: r = min_v;
        MODE_MAX: r = max_v;
        MODE_SUM: r = sum_v;
        MODE_DIFF: begin
          d = last_v - first_v;
          if ((last_v[63] ^ first_v[63]) && (d[63] ^ last_v[63])) return 0;
          r = d;
        end
        default: r = cnt;
      endcase
      return 1;
    endfunction

    function void push(logic [63:0] t, logic [63:0] v, bit st, bit f);
      bucket_res_t e;
      e.bucket_time = t; e.agg = v; e.status = st; e.fin = f;
      pending.push_back(e);
    endfunction

    function void note_point(logic [63:0] ts, logic signed [63:0] v, bit last);
      logic [63:0] r, s;
      if (is_open && ts > open_time) begin
        if (!ovf) begin
          if (agg_of(r)) push(open_time, r, 0, 0);
          else ovf = 1;
        end
        is_open = 0;
      end
      if (!is_open) begin
        is_open = 1; open_time = boundary(ts); cnt = 1;
        first_v = v; last_v = v; min_v = v; max_v = v; sum_v = v;
      end else begin
        s = sum_v + v;
        if (cnt < 64'h7fff_ffff_ffff_ffff) cnt++;
        last_v = v;
        if (v < min_v) min_v = v;
        if (v > max_v) max_v = v;
        if (mode == MODE_SUM && !(sum_v[63] ^ v[63]) && (s[63] ^ sum_v[63])) ovf = 1;
        sum_v = s;
      end
      if (last) begin
        if (!ovf && agg_of(r)) push(open_time, r, 0, 1);
        else push(0, 0, 1, 1);
        clear(); ovf = 0;
      end
    endfunction

    function void check(bucket_res_t got);
      bucket_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat time=%h", got.bucket_time);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.bucket_time !== e.bucket_time) begin
        $error("bucket_time exp %h got %h", e.bucket_time, got.bucket_time); errors++;
      end
      if (got.agg !== e.agg) begin
        $error("aggregate_value exp %h got %h", e.agg, got.agg); errors++;
      end
      if (got.status !== e.status) begin
        $error("status exp %b got %b", e.status, got.status); errors++;
      end
      if (got.fin !== e.fin) begin
        $error("final_result exp %b got %b", e.fin, got.fin); errors++;
      end
    endfunction
  endclass

  bucket_scoreboard sb;
  int  idle_cycles;
  bit  hold_off;
  logic [63:0] cur_ts;

  time_bucket_aggregator i_dut (.*);

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // watchdog on accepted beats
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int g;
    m_tready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    bucket_res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.bucket_time = m_tdata[63:0];
      got.agg = m_tdata[127:64];
      got.status = m_tuser;
      got.fin = m_tlast;
      sb.check(got);
    end
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODE) sb.mode = val[2:0];
    else sb.width = val;
  endtask

  task automatic send_point(logic [63:0] ts, logic [63:0] v, bit last, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1; s_tdata <= {v, ts}; s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_point(ts, v, last);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function logic [63:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 64'h7fff_ffff_ffff_ffff - $urandom_range(0, 3);
      1: return 64'h8000_0000_0000_0000 + $urandom_range(0, 3);
      2: return rand64();
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function logic [31:0] rand_width();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom();
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  // one series of random length with mostly small time steps
  task automatic send_series(int len);
    int k;
    logic [63:0] step;
    for (k = 0; k < len; k++) begin
      case ($urandom_range(0, 9))
        0: step = rand64() >> $urandom_range(0, 63);
        1: step = -$urandom_range(0, 5);
        default: step = $urandom_range(0, 6);
      endcase
      cur_ts = cur_ts + step;
      send_point(cur_ts, rand_val(), k == len - 1, 1);
    end
  endtask

  initial begin
    int n, len;
    sb = new();
    sb.reset();
    hold_off = 0;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_MODE; cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: count with default width, then extremes
    send_point(64'd0, 64'd5, 0, 0);
    send_point(64'd0, 64'd6, 0, 0);
    send_point(64'd3, 64'd7, 1, 0);
    drain();
    write_reg(REG_WIDTH, 32'hffff_ffff);
    write_reg(REG_MODE, MODE_MIN);
    send_point(64'hffff_ffff_ffff_fffe, 64'h8000_0000_0000_0000, 0, 0);
    send_point(64'hffff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, 1, 0);
    drain();
    write_reg(REG_MODE, MODE_MAX);
    write_reg(REG_WIDTH, 32'd0);
    send_point(64'd10, 64'h8000_0000_0000_0000, 0, 0);
    send_point(64'd11, 64'd1, 0, 0);
    send_point(64'd5, 64'd9, 1, 0);
    drain();
    // sum overflow suppresses later groups
    write_reg(REG_MODE, MODE_SUM);
    write_reg(REG_WIDTH, 32'd10);
    send_point(64'd1, 64'h7fff_ffff_ffff_ffff, 0, 0);
    send_point(64'd2, 64'd1, 0, 0);
    send_point(64'd25, 64'd1, 1, 0);
    drain();
    // difference overflow at bucket close, and single-point difference
    write_reg(REG_MODE, MODE_DIFF);
    send_point(64'd1, 64'h8000_0000_0000_0000, 0, 0);
    send_point(64'd2, 64'd1, 0, 0);
    send_point(64'd30, 64'd4, 1, 0);
    drain();
    send_point(64'd7, 64'd4, 1, 0);
    drain();
    write_reg(REG_MODE, 3'd7);
    send_point(64'd4, 64'd1, 0, 0);
    send_point(64'd19, 64'd1, 1, 0);
    drain();

    // long receiver hold-off while points stream in
    write_reg(REG_MODE, MODE_COUNT);
    write_reg(REG_WIDTH, 32'd1);
    hold_off = 1;
    for (int k = 0; k < 8; k++) send_point(64'(k * 2), 64'd1, k == 7, 0);
    drain();

    // random phases with reconfiguration between them
    n = 0;
    while (n < 2000) begin
      write_reg(REG_MODE, 3'($urandom_range(0, 7)));
      write_reg(REG_WIDTH, rand_width());
      cur_ts = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 100));
      for (int sidx = 0; sidx < 4; sidx++) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
        send_series(len);
        n += len;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> time_bucket_aggregator.f
rtl/core/tba_pkg.sv
rtl/core/tba_ctrl.sv
rtl/core/tba_dp.sv
rtl/core/time_bucket_aggregator.sv
dv/tb.sv
